// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/gmlc_pkg.sv
// ----------------------------------------------------------------------------
// gmlc_pkg
// Types and constants shared by the manual gimbal lease controller.
// ----------------------------------------------------------------------------
package gmlc_pkg;

    // Command codes on the input func field
    localparam logic [3:0] FUNC_TICK    = 4'd0;
    localparam logic [3:0] FUNC_ACQUIRE = 4'd1;
    localparam logic [3:0] FUNC_RELEASE = 4'd2;
    localparam logic [3:0] FUNC_RENEW   = 4'd3;
    localparam logic [3:0] FUNC_LEFT    = 4'd4;
    localparam logic [3:0] FUNC_RIGHT   = 4'd5;
    localparam logic [3:0] FUNC_UP      = 4'd6;
    localparam logic [3:0] FUNC_DOWN    = 4'd7;
    localparam logic [3:0] FUNC_CENTER  = 4'd8;
    localparam logic [3:0] FUNC_ZOOM    = 4'd9;

    // Status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_BUSY   = 3'd1;
    localparam logic [2:0] ST_IO     = 3'd2;
    localparam logic [2:0] ST_DENIED = 3'd3;
    localparam logic [2:0] ST_INVAL  = 3'd4;

    // Drive commands
    localparam logic [1:0] DRV_NONE    = 2'd0;
    localparam logic [1:0] DRV_RATES   = 2'd1;
    localparam logic [1:0] DRV_NEUTRAL = 2'd2;
    localparam logic [1:0] DRV_ZOOM    = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_LEASE_MS = 2'd0;
    localparam logic [1:0] CFG_PULSE_MS = 2'd1;
    localparam logic [1:0] CFG_ZOOM_MAX = 2'd2;

    localparam logic [15:0] LEASE_MS_RST = 16'd3000;
    localparam logic [15:0] PULSE_MS_RST = 16'd200;
    localparam logic [15:0] ZOOM_MAX_RST = 16'd2560;

    localparam logic [4:0]  RETRY_MS  = 5'd20;
    localparam logic [15:0] PULSE_MIN = 16'(5 * 256);
    localparam logic [15:0] PULSE_MAX = 16'(60 * 256);
    localparam logic [15:0] ZOOM_MIN  = 16'd256;

    // deg/s Q8.8 to rad/s Q1.14: value * RAD_K / 2^24, rounded half up
    localparam int          RAD_SHIFT = 24;
    localparam int          PROD_W    = 41;
    localparam logic [24:0] RAD_K     = 25'd18740330;
    localparam logic [PROD_W-1:0] RAD_HALF = PROD_W'(1) << (RAD_SHIFT - 1);

    typedef enum logic [2:0] {
        OP_TICK,
        OP_ACQUIRE,
        OP_RELEASE,
        OP_RENEW,
        OP_PULSE,
        OP_CENTER,
        OP_ZOOM,
        OP_INVALID
    } op_t;

    typedef struct packed {
        logic [3:0]  func;
        logic [63:0] token_hi;
        logic [63:0] token_lo;
        logic [63:0] fresh_hi;
        logic [63:0] fresh_lo;
        logic [15:0] value;
        logic        drive_fail;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [63:0]        out_token_hi;
        logic [63:0]        out_token_lo;
        logic [1:0]         drive_cmd;
        logic signed [15:0] pitch_rate;
        logic signed [15:0] yaw_rate;
        logic [15:0]        zoom_value;
    } out_item_t;

    typedef struct packed {
        logic [15:0] lease_ms;
        logic [15:0] pulse_ms;
        logic [15:0] zoom_max;
    } cfg_t;

    // Classified command between front and back
    typedef struct packed {
        op_t                op;
        logic               val_ok;
        logic               fail;
        logic [63:0]        tok_hi;    // fresh bits on acquire, presented token otherwise
        logic [63:0]        tok_lo;
        logic [15:0]        value;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } cmd_t;

endpackage

// File: rtl/gmlc_fifo.sv
// ----------------------------------------------------------------------------
// gmlc_fifo
// Small synchronous queue with same-cycle push and pop.
// ----------------------------------------------------------------------------
module gmlc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/gmlc_front.sv
// ----------------------------------------------------------------------------
// gmlc_front
// Decodes an incoming item, range-checks its value and converts pulse rates.
// ----------------------------------------------------------------------------
module gmlc_front
    import gmlc_pkg::*;
(
    input  in_item_t item,
    input  cfg_t     cfg,
    output cmd_t     entry
);

    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  rounded;
    logic signed [15:0] rate;
    logic signed [15:0] neg_rate;
    logic               pulse_ok;
    logic               zoom_ok;

    always_comb
    begin
        prod     = PROD_W'(item.value) * PROD_W'(RAD_K);
        rounded  = prod + RAD_HALF;
        rate     = rounded[RAD_SHIFT+15:RAD_SHIFT];
        neg_rate = -rate;
        pulse_ok = (item.value >= PULSE_MIN) && (item.value <= PULSE_MAX);
        zoom_ok  = (item.value >= ZOOM_MIN) && (item.value <= cfg.zoom_max);

        entry.fail   = item.drive_fail;
        entry.value  = item.value;
        entry.pitch  = '0;
        entry.yaw    = '0;
        entry.val_ok = 1'b0;
        entry.tok_hi = item.token_hi;
        entry.tok_lo = item.token_lo;

        unique case (item.func)
            FUNC_TICK:    entry.op = OP_TICK;
            FUNC_ACQUIRE:
            begin
                entry.op     = OP_ACQUIRE;
                entry.tok_hi = item.fresh_hi;
                entry.tok_lo = item.fresh_lo;
            end
            FUNC_RELEASE: entry.op = OP_RELEASE;
            FUNC_RENEW:   entry.op = OP_RENEW;
            FUNC_LEFT:
            begin
                entry.op     = OP_PULSE;
                entry.val_ok = pulse_ok;
                entry.yaw    = neg_rate;
            end
            FUNC_RIGHT:
            begin
                entry.op     = OP_PULSE;
                entry.val_ok = pulse_ok;
                entry.yaw    = rate;
            end
            FUNC_UP:
            begin
                entry.op     = OP_PULSE;
                entry.val_ok = pulse_ok;
                entry.pitch  = rate;
            end
            FUNC_DOWN:
            begin
                entry.op     = OP_PULSE;
                entry.val_ok = pulse_ok;
                entry.pitch  = neg_rate;
            end
            FUNC_CENTER:  entry.op = OP_CENTER;
            FUNC_ZOOM:
            begin
                entry.op     = OP_ZOOM;
                entry.val_ok = zoom_ok;
            end
            default:      entry.op = OP_INVALID;
        endcase
    end

endmodule

// File: rtl/gmlc_back.sv
// ----------------------------------------------------------------------------
// gmlc_back
// Executes classified commands against the lease, stop timer and clock.
// ----------------------------------------------------------------------------
module gmlc_back
    import gmlc_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      take,
    input  cmd_t      entry,
    output out_item_t result
);

    logic [TIME_BITS-1:0] now_reg, now_next;
    logic                 lease_active_reg, lease_active_next;
    logic [63:0]          token_hi_reg, token_hi_next;
    logic [63:0]          token_lo_reg, token_lo_next;
    logic [TIME_BITS-1:0] lease_dl_reg, lease_dl_next;
    logic                 stop_pending_reg, stop_pending_next;
    logic [TIME_BITS-1:0] stop_dl_reg, stop_dl_next;

    logic [TIME_BITS-1:0] now_inc;
    logic [TIME_BITS-1:0] stop_base;
    logic                 do_stop;
    logic                 token_ok;

    // Deadline reached when (t - d) mod 2^TIME_BITS has its top bit clear
    function automatic logic reached(input logic [TIME_BITS-1:0] t,
                                     input logic [TIME_BITS-1:0] d);
        logic [TIME_BITS-1:0] diff;
        diff = t - d;
        return !diff[TIME_BITS-1];
    endfunction

    always_comb
    begin
        now_inc  = now_reg + 1'b1;
        token_ok = lease_active_reg && (entry.tok_hi == token_hi_reg)
                   && (entry.tok_lo == token_lo_reg);

        now_next          = now_reg;
        lease_active_next = lease_active_reg;
        token_hi_next     = token_hi_reg;
        token_lo_next     = token_lo_reg;
        lease_dl_next     = lease_dl_reg;
        stop_pending_next = stop_pending_reg;
        stop_dl_next      = stop_dl_reg;
        do_stop           = 1'b0;
        stop_base         = now_reg;

        result = '0;

        unique case (entry.op)
            OP_TICK:
            begin
                now_next  = now_inc;
                stop_base = now_inc;
                if (lease_active_reg && reached(now_inc, lease_dl_reg))
                begin
                    do_stop           = 1'b1;
                    lease_active_next = 1'b0;
                    token_hi_next     = '0;
                    token_lo_next     = '0;
                end
                else if (stop_pending_reg && reached(now_inc, stop_dl_reg))
                begin
                    do_stop = 1'b1;
                end
            end
            OP_ACQUIRE:
            begin
                if (lease_active_reg)
                begin
                    result.status = ST_BUSY;
                end
                else
                begin
                    do_stop = 1'b1;
                    if (entry.fail)
                    begin
                        result.status = ST_IO;
                    end
                    else
                    begin
                        lease_active_next   = 1'b1;
                        token_hi_next       = entry.tok_hi;
                        token_lo_next       = entry.tok_lo;
                        lease_dl_next       = now_reg + TIME_BITS'(cfg.lease_ms);
                        result.out_token_hi = entry.tok_hi;
                        result.out_token_lo = entry.tok_lo;
                    end
                end
            end
            OP_RELEASE:
            begin
                if (!token_ok)
                begin
                    result.status = ST_DENIED;
                end
                else
                begin
                    do_stop = 1'b1;
                    if (entry.fail)
                    begin
                        result.status = ST_IO;
                    end
                    else
                    begin
                        lease_active_next = 1'b0;
                        token_hi_next     = '0;
                        token_lo_next     = '0;
                    end
                end
            end
            OP_RENEW:
            begin
                if (!token_ok)
                begin
                    result.status = ST_DENIED;
                end
                else
                begin
                    lease_dl_next = now_reg + TIME_BITS'(cfg.lease_ms);
                end
            end
            OP_PULSE:
            begin
                if (!token_ok)
                begin
                    result.status = ST_DENIED;
                end
                else if (!entry.val_ok)
                begin
                    result.status = ST_INVAL;
                end
                else
                begin
                    result.drive_cmd  = DRV_RATES;
                    result.pitch_rate = entry.pitch;
                    result.yaw_rate   = entry.yaw;
                    // stop is armed whether or not the drive took the command
                    stop_pending_next = 1'b1;
                    stop_dl_next      = now_reg + TIME_BITS'(cfg.pulse_ms);
                    if (entry.fail)
                    begin
                        result.status = ST_IO;
                    end
                end
            end
            OP_CENTER:
            begin
                if (!token_ok)
                begin
                    result.status = ST_DENIED;
                end
                else
                begin
                    result.drive_cmd = DRV_NEUTRAL;
                    if (entry.fail)
                    begin
                        result.status = ST_IO;
                    end
                    else
                    begin
                        stop_pending_next = 1'b0;
                    end
                end
            end
            OP_ZOOM:
            begin
                if (!token_ok)
                begin
                    result.status = ST_DENIED;
                end
                else if (!entry.val_ok)
                begin
                    result.status = ST_INVAL;
                end
                else
                begin
                    result.drive_cmd  = DRV_ZOOM;
                    result.zoom_value = entry.value;
                    if (entry.fail)
                    begin
                        result.status = ST_IO;
                    end
                end
            end
            OP_INVALID:
            begin
                result.status = token_ok ? ST_IO : ST_DENIED;
            end
        endcase

        // zero-rate stop; a rejected stop retries later
        if (do_stop)
        begin
            result.drive_cmd = DRV_RATES;
            if (entry.fail)
            begin
                stop_pending_next = 1'b1;
                stop_dl_next      = stop_base + TIME_BITS'(RETRY_MS);
            end
            else
            begin
                stop_pending_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg          <= '0;
            lease_active_reg <= 1'b0;
            token_hi_reg     <= '0;
            token_lo_reg     <= '0;
            lease_dl_reg     <= '0;
            stop_pending_reg <= 1'b0;
            stop_dl_reg      <= '0;
        end
        else if (take)
        begin
            now_reg          <= now_next;
            lease_active_reg <= lease_active_next;
            token_hi_reg     <= token_hi_next;
            token_lo_reg     <= token_lo_next;
            lease_dl_reg     <= lease_dl_next;
            stop_pending_reg <= stop_pending_next;
            stop_dl_reg      <= stop_dl_next;
        end
    end

endmodule

// File: rtl/gimbal_manual_lease_controller.sv
// ----------------------------------------------------------------------------
// gimbal_manual_lease_controller
// Token-guarded lease for manual gimbal rate, neutral and zoom commands.
// Throughput: one item per cycle; the back end executes one command per cycle
//   while the result queue has room.
// Reset (rst_n, async): queues empty, lease and timers cleared, registers
//   back to their defaults. No clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gimbal_manual_lease_controller
    import gmlc_pkg::*;
#(
    parameter int TIME_BITS   = 32,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    item,
    output logic        empty,
    input  logic        pop,
    output out_item_t   result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [15:0] cfg_data
);

    cfg_t      cfg_reg;
    cmd_t      front_cmd;
    cmd_t      back_cmd;
    out_item_t back_result;
    logic      cmd_empty;
    logic      res_full;
    logic      take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lease_ms <= LEASE_MS_RST;
            cfg_reg.pulse_ms <= PULSE_MS_RST;
            cfg_reg.zoom_max <= ZOOM_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_LEASE_MS: cfg_reg.lease_ms <= cfg_data;
                CFG_PULSE_MS: cfg_reg.pulse_ms <= cfg_data;
                CFG_ZOOM_MAX: cfg_reg.zoom_max <= cfg_data;
                default:      ;
            endcase
        end
    end

    gmlc_front u_front (
        .item  (item),
        .cfg   (cfg_reg),
        .entry (front_cmd)
    );

    gmlc_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_cmd),
        .full    (full),
        .rd_en   (take),
        .rd_data (back_cmd),
        .empty   (cmd_empty)
    );

    assign take = !cmd_empty && !res_full;

    gmlc_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .take   (take),
        .entry  (back_cmd),
        .result (back_result)
    );

    gmlc_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (take),
        .wr_data (back_result),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

    // accepted item is queued for the back end on the next cycle
    `ASSERT_NEXT(a_push_queued, clk, rst_n, push && !full, !cmd_empty)
    // an executed command always leaves a result to pop
    `ASSERT_NEXT(a_exec_result, clk, rst_n, take, !empty)
    // back end only runs with room for its result
    `ASSERT_SAME(a_exec_room, clk, rst_n, take, !res_full && !cmd_empty)

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the manual gimbal lease controller. A scoreboard
// keeps its own copy of the lease, token and timer state, predicts one
// response per accepted command and compares it, field by field, with each
// popped response. Stimulus is a short directed pass, then random lease
// sessions under several register settings with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top
    import gmlc_pkg::*;
;

    localparam logic [3:0]  FUNC_UNUSED_LO = 4'd10;
    localparam logic [3:0]  FUNC_UNUSED_HI = 4'd15;
    localparam logic [31:0] RETRY_DELAY_MS = 32'd20;
    localparam logic [15:0] RATE_MIN_Q8    = 16'd1280;   // 5 deg/s
    localparam logic [15:0] RATE_MAX_Q8    = 16'd15360;  // 60 deg/s
    localparam logic [15:0] ZOOM_FLOOR_Q8  = 16'd256;    // 1.0
    localparam logic [63:0] DEG2RAD_Q24    = 64'd18740330;
    localparam int          TIMEOUT_NS     = 2_000_000;
    localparam int          ITEMS_PER_PHASE = 117;

    // ------------------------------------------------------------------------
    // Scoreboard: lease state, command predictor and response queue
    // ------------------------------------------------------------------------
    class lease_scoreboard;
        logic [15:0] lease_ms;
        logic [15:0] pulse_ms;
        logic [15:0] zoom_max;
        logic [31:0] clock_ms;
        logic        lease_active;
        logic [63:0] lease_hi;
        logic [63:0] lease_lo;
        logic [31:0] lease_deadline;
        logic        stop_pending;
        logic [31:0] stop_deadline;
        out_item_t   expected[$];
        int unsigned mismatches;

        function new();
            lease_ms       = 16'd3000;
            pulse_ms       = 16'd200;
            zoom_max       = 16'd2560;
            clock_ms       = '0;
            lease_active   = 1'b0;
            lease_hi       = '0;
            lease_lo       = '0;
            lease_deadline = '0;
            stop_pending   = 1'b0;
            stop_deadline  = '0;
            mismatches     = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_LEASE_MS: lease_ms = data;
                CFG_PULSE_MS: pulse_ms = data;
                CFG_ZOOM_MAX: zoom_max = data;
                default: ;
            endcase
        endfunction

        // wrapping time: reached when (now - deadline) is non-negative
        function bit deadline_reached(logic [31:0] deadline);
            logic [31:0] diff;
            diff = clock_ms - deadline;
            return !diff[31];
        endfunction

        // zero-rate stop; a rejected stop is retried later
        function void issue_stop(logic fail);
            if (fail)
            begin
                stop_pending  = 1'b1;
                stop_deadline = clock_ms + RETRY_DELAY_MS;
            end
            else
            begin
                stop_pending = 1'b0;
            end
        endfunction

        function out_item_t predict_response(in_item_t c);
            out_item_t   r;
            logic [63:0] prod;
            logic [15:0] rate;
            logic        token_ok;
            r = '0;
            r.status    = ST_OK;
            r.drive_cmd = DRV_NONE;
            token_ok = lease_active && lease_hi == c.token_hi && lease_lo == c.token_lo;
            if (c.func == FUNC_TICK)
            begin
                clock_ms = clock_ms + 32'd1;
                if (lease_active && deadline_reached(lease_deadline))
                begin
                    r.drive_cmd = DRV_RATES;
                    issue_stop(c.drive_fail);
                    lease_active = 1'b0;
                    lease_hi     = '0;
                    lease_lo     = '0;
                end
                if (stop_pending && deadline_reached(stop_deadline))
                begin
                    r.drive_cmd = DRV_RATES;
                    issue_stop(c.drive_fail);
                end
            end
            else if (c.func == FUNC_ACQUIRE)
            begin
                if (lease_active)
                    r.status = ST_BUSY;
                else
                begin
                    r.drive_cmd = DRV_RATES;
                    issue_stop(c.drive_fail);
                    if (c.drive_fail)
                        r.status = ST_IO;
                    else
                    begin
                        lease_active   = 1'b1;
                        lease_hi       = c.fresh_hi;
                        lease_lo       = c.fresh_lo;
                        lease_deadline = clock_ms + 32'(lease_ms);
                        r.out_token_hi = c.fresh_hi;
                        r.out_token_lo = c.fresh_lo;
                    end
                end
            end
            else if (!token_ok)
                r.status = ST_DENIED;
            else
            begin
                case (c.func)
                    FUNC_RELEASE:
                    begin
                        r.drive_cmd = DRV_RATES;
                        issue_stop(c.drive_fail);
                        if (c.drive_fail)
                            r.status = ST_IO;
                        else
                        begin
                            lease_active = 1'b0;
                            lease_hi     = '0;
                            lease_lo     = '0;
                        end
                    end
                    FUNC_RENEW:
                        lease_deadline = clock_ms + 32'(lease_ms);
                    FUNC_LEFT, FUNC_RIGHT, FUNC_UP, FUNC_DOWN:
                    begin
                        if (c.value < RATE_MIN_Q8 || c.value > RATE_MAX_Q8)
                            r.status = ST_INVAL;
                        else
                        begin
                            // deg/s Q8.8 to rad/s Q1.14, rounded half up
                            prod = 64'(c.value) * DEG2RAD_Q24 + (64'd1 << 23);
                            rate = prod[24 +: 16];
                            case (c.func)
                                FUNC_LEFT:  r.yaw_rate   = -rate;
                                FUNC_RIGHT: r.yaw_rate   = rate;
                                FUNC_UP:    r.pitch_rate = rate;
                                default:    r.pitch_rate = -rate;
                            endcase
                            r.drive_cmd   = DRV_RATES;
                            stop_pending  = 1'b1;
                            stop_deadline = clock_ms + 32'(pulse_ms);
                            if (c.drive_fail)
                                r.status = ST_IO;
                        end
                    end
                    FUNC_CENTER:
                    begin
                        r.drive_cmd = DRV_NEUTRAL;
                        if (c.drive_fail)
                            r.status = ST_IO;
                        else
                            stop_pending = 1'b0;
                    end
                    FUNC_ZOOM:
                    begin
                        if (c.value < ZOOM_FLOOR_Q8 || c.value > zoom_max)
                            r.status = ST_INVAL;
                        else
                        begin
                            r.drive_cmd  = DRV_ZOOM;
                            r.zoom_value = c.value;
                            if (c.drive_fail)
                                r.status = ST_IO;
                        end
                    end
                    default:
                        r.status = ST_IO;
                endcase
            end
            return r;
        endfunction

        function void note_command(in_item_t c);
            expected.push_back(predict_response(c));
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %h, actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_response(out_item_t got);
            out_item_t want;
            if (expected.size() == 0)
            begin
                $display("%0t: response expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = expected.pop_front();
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("out_token_hi", want.out_token_hi, got.out_token_hi);
            compare_field("out_token_lo", want.out_token_lo, got.out_token_lo);
            compare_field("drive_cmd", 64'(want.drive_cmd), 64'(got.drive_cmd));
            compare_field("pitch_rate", 64'(want.pitch_rate), 64'(got.pitch_rate));
            compare_field("yaw_rate", 64'(want.yaw_rate), 64'(got.yaw_rate));
            compare_field("zoom_value", 64'(want.zoom_value), 64'(got.zoom_value));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and its drive signals
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n    = 1'b0;
    logic        push     = 1'b0;
    logic        full;
    in_item_t    item     = '0;
    logic        empty;
    logic        pop      = 1'b0;
    out_item_t   result;
    logic        cfg_we   = 1'b0;
    logic [1:0]  cfg_idx  = CFG_LEASE_MS;
    logic [15:0] cfg_data = '0;

    lease_scoreboard sb = new();
    int send_idle_pct = 10;
    int recv_idle_pct = 60;
    int hold_req      = 0;

    gimbal_manual_lease_controller dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic in_item_t make_cmd(logic [3:0] f, logic [63:0] hi, logic [63:0] lo,
                                          logic [15:0] v, logic fail);
        in_item_t c;
        c.func       = f;
        c.token_hi   = hi;
        c.token_lo   = lo;
        c.fresh_hi   = rand64();
        c.fresh_lo   = rand64();
        c.value      = v;
        c.drive_fail = fail;
        return c;
    endfunction

    // mostly well-formed session traffic under the held token, some noise
    function automatic in_item_t random_command();
        in_item_t c;
        int       pick;
        int       sub;
        int       b;
        c = make_cmd(FUNC_TICK, rand64(), rand64(), 16'($urandom()),
                     $urandom_range(99) < 20);
        pick = $urandom_range(99);
        if (pick < 35)
            c.func = FUNC_TICK;
        else if (pick < 45 || (!sb.lease_active && pick < 65))
            c.func = FUNC_ACQUIRE;
        else if (pick < 92)
        begin
            c.token_hi = sb.lease_hi;
            c.token_lo = sb.lease_lo;
            sub = $urandom_range(99);
            if (sub < 4)
                c.func = FUNC_RELEASE;
            else if (sub < 10)
                c.func = FUNC_RENEW;
            else if (sub < 62)
            begin
                c.func = FUNC_LEFT + 4'($urandom_range(3));
                if ($urandom_range(9) != 0)
                    c.value = 16'($urandom_range(RATE_MAX_Q8, RATE_MIN_Q8));
            end
            else if (sub < 74)
                c.func = FUNC_CENTER;
            else if (sub < 92)
            begin
                c.func = FUNC_ZOOM;
                if (sb.zoom_max >= ZOOM_FLOOR_Q8 && $urandom_range(9) != 0)
                    c.value = 16'($urandom_range(sb.zoom_max, ZOOM_FLOOR_Q8));
            end
            else
                c.func = 4'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
        end
        else
        begin
            c.func = 4'($urandom());
            if ($urandom_range(1) != 0)
            begin
                // near miss: held token with one bit flipped
                c.token_hi = sb.lease_hi;
                c.token_lo = sb.lease_lo;
                b = $urandom_range(127);
                if (b < 64)
                    c.token_hi[b] = ~c.token_hi[b];
                else
                    c.token_lo[b - 64] = ~c.token_lo[b - 64];
            end
        end
        return c;
    endfunction

    task automatic send_command(in_item_t c);
        item <= c;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_command(c);
        if ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    // stop offering and wait until every predicted response has been popped
    task automatic drain_results();
        push <= 1'b0;
        while (sb.expected.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [15:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.set_register(idx, data);
    endtask

    task automatic program_settings(logic [15:0] lease, logic [15:0] pulse,
                                    logic [15:0] zoom);
        write_register(CFG_LEASE_MS, lease);
        write_register(CFG_PULSE_MS, pulse);
        write_register(CFG_ZOOM_MAX, zoom);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Response side: pops with random stalls, long hold-offs on request
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check_response(result);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------
    initial
    begin
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        in_item_t    c;
        int          lease_set[6];
        int          pulse_set[6];
        int          zoom_set[6];

        lease_set = '{3000, 1, 0, 40, 65535, 12};
        pulse_set = '{200, 1, 0, 10, 65535, 5};
        zoom_set  = '{2560, 256, 255, 2560, 65535, 1000};
        key_hi = '1;
        key_lo = '1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass
        program_settings(16'd5, 16'd3, 16'hFFFF);
        send_command(make_cmd(FUNC_TICK, '0, '0, '0, 1'b0));
        send_command(make_cmd(FUNC_RENEW, '0, '0, '0, 1'b0));          // no lease
        send_command(make_cmd(FUNC_UNUSED_HI, '1, '1, '1, 1'b0));      // no lease
        send_command(make_cmd(FUNC_ACQUIRE, '0, '0, '0, 1'b1));        // stop rejected
        c = make_cmd(FUNC_ACQUIRE, '0, '0, '0, 1'b0);
        c.fresh_hi = key_hi;
        c.fresh_lo = key_lo;
        send_command(c);
        send_command(make_cmd(FUNC_ACQUIRE, '0, '0, '0, 1'b0));        // already held
        send_command(make_cmd(FUNC_LEFT, key_hi, key_lo, RATE_MIN_Q8, 1'b0));
        send_command(make_cmd(FUNC_RIGHT, key_hi, key_lo, RATE_MAX_Q8, 1'b0));
        send_command(make_cmd(FUNC_UP, key_hi, key_lo, RATE_MIN_Q8 - 16'd1, 1'b0));
        send_command(make_cmd(FUNC_DOWN, key_hi, key_lo, 16'hFFFF, 1'b1));
        send_command(make_cmd(FUNC_DOWN, key_hi, key_lo, 16'd3000, 1'b1));
        send_command(make_cmd(FUNC_ZOOM, key_hi, key_lo, ZOOM_FLOOR_Q8 - 16'd1, 1'b0));
        send_command(make_cmd(FUNC_ZOOM, key_hi, key_lo, 16'hFFFF, 1'b0));
        send_command(make_cmd(FUNC_ZOOM, key_hi, key_lo, ZOOM_FLOOR_Q8, 1'b1));
        send_command(make_cmd(FUNC_CENTER, key_hi, key_lo, '0, 1'b1));
        send_command(make_cmd(FUNC_UNUSED_LO, key_hi, key_lo, '0, 1'b0));
        send_command(make_cmd(FUNC_RENEW, key_hi, key_lo ^ 64'd1, '0, 1'b0));
        send_command(make_cmd(FUNC_RENEW, key_hi ^ (64'd1 << 63), key_lo, '0, 1'b0));
        send_command(make_cmd(FUNC_RENEW, key_hi, key_lo, '0, 1'b0));
        // pulse stop comes due on the third tick and is rejected
        send_command(make_cmd(FUNC_TICK, '0, '0, '0, 1'b0));
        send_command(make_cmd(FUNC_TICK, '0, '0, '0, 1'b0));
        send_command(make_cmd(FUNC_TICK, '0, '0, '0, 1'b1));
        send_command(make_cmd(FUNC_RELEASE, key_hi, key_lo, '0, 1'b1));
        send_command(make_cmd(FUNC_RELEASE, key_hi, key_lo, '0, 1'b0));

        // random sessions, one register setting per phase
        for (int p = 0; p < 6; p++)
        begin
            drain_results();
            program_settings(16'(lease_set[p]), 16'(pulse_set[p]), 16'(zoom_set[p]));
            if (p == 2)
            begin
                send_idle_pct = 60;
                recv_idle_pct = 10;
            end
            else if (p == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // back-pressure: receiver holds off while commands keep coming
            if (p == 0 || p == 3)
                hold_req = 150;
            repeat (ITEMS_PER_PHASE) send_command(random_command());
        end

        drain_results();
        if (sb.mismatches == 0 && sb.expected.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/gmlc_pkg.sv
rtl/gmlc_fifo.sv
rtl/gmlc_front.sv
rtl/gmlc_back.sv
rtl/gimbal_manual_lease_controller.sv
tb/sv/tb_top.sv
